FILE: rtl/core/audio_frame_volume_dac_formatter_core_defines.svh
// ----------------------------------------------------------------------------
// audio frame volume dac formatter core - assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef AUDIO_FRAME_VOLUME_DAC_FORMATTER_CORE_DEFINES_SVH
`define AUDIO_FRAME_VOLUME_DAC_FORMATTER_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define AFVDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afvdf assertion failed");
// next-cycle implication
`define AFVDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afvdf assertion failed");
`else
`define AFVDF_ASSERT_IMP(lbl, ante, cons)
`define AFVDF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/afvdf_pkg.sv
// ----------------------------------------------------------------------------
// afvdf_pkg
// shared widths, codes and the gain reciprocal
// ----------------------------------------------------------------------------
package afvdf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 7;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int FILL_W      = 8;

  localparam logic [FILL_W-1:0] CHUNK_FRAMES = 8'd180;

  // gain of one hundred percent
  localparam logic [GAIN_W-1:0] GAIN_FULL = 7'd100;

  // reciprocal scaling: floor(m * g / 100) == (m * recip) >> 22 for 16-bit
  // magnitudes whenever recip lies in [g * 2^22 / 100, g * 2^22 / 100 + 1.28)
  // recip = ceil(g * ceil(2^31 / 100) / 2^9) lands there for every g up to 100
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = 23;
  localparam int RECIP_NUM_W = 32;
  localparam int RECIP_FRAC  = 9;
  localparam logic [RECIP_NUM_W-1:0] RECIP_MUL   = 32'd21474837;
  localparam logic [RECIP_NUM_W-1:0] RECIP_ROUND = 32'd511;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MUTE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  // output modes
  localparam logic [MODE_W-1:0] MODE_EXT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MONO_L = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MONO_R = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DIFF   = 2'd3;

  // dac word constants
  localparam logic [SAMPLE_W-1:0]        OFFSET_WORD  = 16'h8000;
  localparam logic signed [SAMPLE_W-1:0] DIFF_LIMIT   = 16'sh7F00;
  localparam logic signed [SAMPLE_W-1:0] DIFF_LIMIT_N = 16'sh8100;
  localparam logic [SAMPLE_W-1:0]        DIFF_STEP    = 16'h0100;
  localparam logic [SAMPLE_W-1:0]        DIFF_HI_WORD = 16'hFF00;
  localparam logic [SAMPLE_W-1:0]        DIFF_LO_WORD = 16'h0100;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SAMPLE_W-1:0]        word_t;

  function automatic logic [RECIP_W-1:0] gain_recip(input logic [GAIN_W-1:0] gain);
    logic [RECIP_NUM_W-1:0] num;
    num = RECIP_NUM_W'(gain) * RECIP_MUL + RECIP_ROUND;
    return RECIP_W'(num >> RECIP_FRAC);
  endfunction

endpackage

FILE: rtl/core/audio_frame_volume_dac_formatter_core.sv
// ----------------------------------------------------------------------------
// audio_frame_volume_dac_formatter_core
// stereo frame gain, dac word formatting and dma chunk marking
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in      | sink      | in_valid / in_stall  | left/right sample, last in batch
//   out     | source    | out_valid/out_stall  | left/right word, chunk end
//   cfg     | sink      | cfg_we               | cfg_index, cfg_wdata
//
// one word per cycle sustained while out_stall is low; three register stages
// (input, scaled, output) lie between an accepted frame and out_valid
// the per-channel 16x23 reciprocal multiply sets the input-to-scaled path;
// the gain reciprocal is registered and follows a volume or mute write in the next cycle
// in_stall is high only when all three stages hold words and out_stall is high
// synchronous active-low reset clears the valid bits, chunk fill and registers
// to their defaults (volume 100, unmuted, external mode)
//
`include "audio_frame_volume_dac_formatter_core_defines.svh"

module audio_frame_volume_dac_formatter_core
  import afvdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input frames
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sample_t               in_left_sample,
  input  sample_t               in_right_sample,
  input  logic                  in_last_in_batch,
  // output words
  output logic                  out_valid,
  input  logic                  out_stall,
  output word_t                 out_left_word,
  output word_t                 out_right_word,
  output logic                  out_chunk_end
);

  // config registers
  logic [GAIN_W-1:0] volume_r;
  logic              mute_r;
  logic [MODE_W-1:0] mode_r;

  // chunk counter
  logic [FILL_W-1:0] chunk_fill_r, chunk_fill_nxt;
  logic [FILL_W:0]   fill_inc;
  logic              chunk_end;

  // stage one: raw frame
  logic    s1_valid_r;
  sample_t s1_left_r, s1_right_r;
  logic    s1_end_r;

  // stage two: scaled frame
  logic    s2_valid_r;
  sample_t s2_left_r, s2_right_r;
  logic    s2_end_r;

  // output stage
  logic  out_valid_r;
  word_t out_left_r, out_right_r;
  logic  out_end_r;

  logic adv_out, adv_s2, adv_s1, in_accept;

  logic [GAIN_W-1:0]  gain;
  logic [RECIP_W-1:0] recip_r;
  sample_t            left_scaled, right_scaled;
  word_t              left_fmt, right_fmt;

  // pipeline advance, back to front
  assign adv_out   = !out_valid_r || !out_stall;
  assign adv_s2    = !s2_valid_r || adv_out;
  assign adv_s1    = !s1_valid_r || adv_s2;
  assign in_stall  = !adv_s1;
  assign in_accept = in_valid && adv_s1;

  // config writes, index 3 is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= GAIN_FULL;
      mute_r   <= 1'b0;
      mode_r   <= MODE_EXT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOLUME: volume_r <= cfg_wdata[GAIN_W-1:0];
        REG_MUTE:   mute_r   <= cfg_wdata[0];
        REG_MODE:   mode_r   <= cfg_wdata[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // chunk close on batch end or full chunk
  assign fill_inc       = {1'b0, chunk_fill_r} + 9'd1;
  assign chunk_end      = in_last_in_batch || (fill_inc >= {1'b0, CHUNK_FRAMES});
  assign chunk_fill_nxt = chunk_end ? '0 : fill_inc[FILL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_fill_r <= '0;
    end else if (in_accept) begin
      chunk_fill_r <= chunk_fill_nxt;
    end
  end

  // stage one capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv_s1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s1) begin
      s1_left_r  <= in_left_sample;
      s1_right_r <= in_right_sample;
      s1_end_r   <= chunk_end;
    end
  end

  // gain clamps at one hundred percent, mute forces zero
  assign gain = mute_r ? '0 : ((volume_r > GAIN_FULL) ? GAIN_FULL : volume_r);

  // reciprocal is registered from the config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_r <= gain_recip(GAIN_FULL);
    end else begin
      recip_r <= gain_recip(gain);
    end
  end

  afvdf_scale u_scale_left (
    .sample (s1_left_r),
    .recip  (recip_r),
    .scaled (left_scaled)
  );

  afvdf_scale u_scale_right (
    .sample (s1_right_r),
    .recip  (recip_r),
    .scaled (right_scaled)
  );

  // stage two capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv_s2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s2) begin
      s2_left_r  <= left_scaled;
      s2_right_r <= right_scaled;
      s2_end_r   <= s1_end_r;
    end
  end

  afvdf_format u_format (
    .left       (s2_left_r),
    .right      (s2_right_r),
    .mode       (mode_r),
    .left_word  (left_fmt),
    .right_word (right_fmt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_left_r  <= left_fmt;
      out_right_r <= right_fmt;
      out_end_r   <= s2_end_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left_word  = out_left_r;
  assign out_right_word = out_right_r;
  assign out_chunk_end  = out_end_r;

  // checks
  `AFVDF_ASSERT_IMP(a_fill_below_chunk, 1'b1, chunk_fill_r < CHUNK_FRAMES)
  `AFVDF_ASSERT_IMP(a_stall_means_full, in_stall, s1_valid_r && s2_valid_r && out_valid_r)
  `AFVDF_ASSERT_NEXT(a_full_chunk_wraps,
                     in_accept && (fill_inc == {1'b0, CHUNK_FRAMES}), chunk_fill_r == '0)

endmodule

FILE: rtl/core/afvdf_scale.sv
// ----------------------------------------------------------------------------
// afvdf_scale
// one channel gain stage, truncating toward zero
// ----------------------------------------------------------------------------
module afvdf_scale
  import afvdf_pkg::*;
(
  input  sample_t            sample,
  input  logic [RECIP_W-1:0] recip,
  output sample_t            scaled
);

  logic [SAMPLE_W-1:0]         mag;
  logic [SAMPLE_W+RECIP_W-1:0] prod;
  logic [SAMPLE_W-1:0]         quo;

  // magnitude, most negative sample maps to 0x8000
  assign mag  = sample[SAMPLE_W-1] ? (~sample + 16'd1) : sample;
  assign prod = (SAMPLE_W+RECIP_W)'(mag) * (SAMPLE_W+RECIP_W)'(recip);
  assign quo  = prod[RECIP_SHIFT +: SAMPLE_W];
  assign scaled = sample[SAMPLE_W-1] ? sample_t'(~quo + 16'd1) : sample_t'(quo);

endmodule

FILE: rtl/core/afvdf_format.sv
// ----------------------------------------------------------------------------
// afvdf_format
// mono mix and dac word formatting
// ----------------------------------------------------------------------------
module afvdf_format
  import afvdf_pkg::*;
(
  input  sample_t           left,
  input  sample_t           right,
  input  logic [MODE_W-1:0] mode,
  output word_t             left_word,
  output word_t             right_word
);

  logic [SAMPLE_W:0] sum;
  sample_t           mix;

  // floor of the half sum
  assign sum = {left[SAMPLE_W-1], left} + {right[SAMPLE_W-1], right};
  assign mix = sample_t'(sum[SAMPLE_W:1]);

  always_comb begin
    left_word  = word_t'(left);
    right_word = word_t'(right);
    unique case (mode)
      MODE_EXT: begin
        left_word  = word_t'(left);
        right_word = word_t'(right);
      end
      MODE_MONO_L: begin
        left_word  = word_t'(mix) ^ OFFSET_WORD;
        right_word = '0;
      end
      MODE_MONO_R: begin
        left_word  = '0;
        right_word = word_t'(mix) ^ OFFSET_WORD;
      end
      MODE_DIFF: begin
        if (mix > DIFF_LIMIT) begin
          left_word  = word_t'(mix) + DIFF_STEP;
          right_word = DIFF_HI_WORD;
        end else if (mix < DIFF_LIMIT_N) begin
          left_word  = word_t'(mix) - DIFF_STEP;
          right_word = DIFF_LO_WORD;
        end else begin
          left_word  = OFFSET_WORD;
          right_word = word_t'(mix) ^ OFFSET_WORD;
        end
      end
      default: begin
        left_word  = word_t'(left);
        right_word = word_t'(right);
      end
    endcase
  end

endmodule
